@@ design/utf8v_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, constants and the lead-byte decoder for the UTF-8 validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD2_MIN     = 8'hC2;
    localparam logic [7:0] LEAD2_MAX     = 8'hDF;
    localparam logic [7:0] LEAD3_E0      = 8'hE0;
    localparam logic [7:0] LEAD3_ED      = 8'hED;
    localparam logic [7:0] LEAD3_MAX     = 8'hEF;
    localparam logic [7:0] LEAD4_F0      = 8'hF0;
    localparam logic [7:0] LEAD4_F4      = 8'hF4;
    localparam logic [7:0] CONT_LO       = 8'h80;
    localparam logic [7:0] CONT_HI       = 8'hBF;
    localparam logic [7:0] CONT_LO_E0    = 8'hA0;
    localparam logic [7:0] CONT_HI_ED    = 8'h9F;
    localparam logic [7:0] CONT_LO_F0    = 8'h90;
    localparam logic [7:0] CONT_HI_F4    = 8'h8F;
    localparam logic [7:0] LATIN_HI_BASE = 8'hC0;
    localparam logic [7:0] LATIN_LO_BASE = 8'h80;
    localparam logic [7:0] LATIN_MASK    = 8'h3F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_CHECK,
        S_EMIT,
        S_FLUSH
    } t_state;

    // continuation count (0 = not a lead) and bounds on the first continuation
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_lead;

    // sequencer to output stage
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       flush;
        logic       eop;
    } t_emit_ctl;

    function automatic t_lead lead_info(input logic [7:0] c);
        t_lead r;
        r.len = 2'd0;
        r.lo  = CONT_LO;
        r.hi  = CONT_HI;
        if (c >= LEAD2_MIN && c <= LEAD2_MAX) begin
            r.len = 2'd1;
        end else if (c >= LEAD3_E0 && c <= LEAD3_MAX) begin
            r.len = 2'd2;
            if (c == LEAD3_E0) r.lo = CONT_LO_E0;
            if (c == LEAD3_ED) r.hi = CONT_HI_ED;
        end else if (c >= LEAD4_F0 && c <= LEAD4_F4) begin
            r.len = 2'd3;
            if (c == LEAD4_F0) r.lo = CONT_LO_F0;
            if (c == LEAD4_F4) r.hi = CONT_HI_F4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/utf8v_out_stage.sv @@
// ----------------------------------------------------------------------------
// utf8v_out_stage
// One-byte staging slot plus output register. A byte is only known to be the
// last of its step once the sequencer flushes, so each byte waits in the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire utf8v_pkg::t_emit_ctl i_ctl,
    output logic                      o_can,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_of_run,
    output logic                      o_end_of_output
);

    logic       r_stg_v, n_stg_v;
    logic [7:0] r_stg_byte, n_stg_byte;
    logic       r_out_v, n_out_v;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       r_out_eop, n_out_eop;
    logic       out_free;
    logic       load_out;

    assign out_free = !r_out_v || !i_stall;
    assign o_can    = !r_stg_v || out_free;
    assign load_out = o_can && r_stg_v && (i_ctl.push || i_ctl.flush);

    always_comb begin
        n_stg_v    = r_stg_v;
        n_stg_byte = r_stg_byte;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_out_eop  = r_out_eop;
        n_out_v    = out_free ? 1'b0 : r_out_v;
        if (load_out) begin
            n_out_v    = 1'b1;
            n_out_byte = r_stg_byte;
            n_out_last = i_ctl.flush;
            n_out_eop  = i_ctl.flush && i_ctl.eop;
        end
        if (o_can && i_ctl.push) begin
            n_stg_v    = 1'b1;
            n_stg_byte = i_ctl.data;
        end else if (o_can && i_ctl.flush) begin
            n_stg_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_stg_v <= n_stg_v;
            r_out_v <= n_out_v;
        end
        r_stg_byte <= n_stg_byte;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_eop  <= n_out_eop;
    end

    assign o_valid         = r_out_v;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_output = r_out_eop;

    // a flush taken while o_can is high leaves the slot empty afterwards
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.flush && o_can) |=> !r_stg_v)
        else $error("staging slot not emptied by flush");

    // output register only loads from a valid slot
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_stg_v && !(i_ctl.push && o_can)) |=> (r_out_v -> $past(r_out_v)))
        else $error("output loaded without staged byte");

    // push and flush are exclusive
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.flush))
        else $error("push and flush together");

endmodule

`default_nettype wire

@@ design/utf8_validate_latin1_repair.sv @@
// ----------------------------------------------------------------------------
// utf8_validate_latin1_repair
// UTF-8 validator that re-encodes bad lead bytes as two-byte Latin-1 UTF-8.
//
// Input channel: one text byte per item with end_of_text on the final byte
// of a string. Output channel: one sanitized byte per item; last_of_run
// marks the final byte caused by one input item, end_of_output the final
// byte of the string. Both channels use valid/stall; o_stall is high while
// an item is being worked.
// A four-entry byte queue (held bytes plus the new one) is scanned by a
// small sequencer that decodes the lead byte, checks one continuation byte
// per cycle in a shared range comparator, then emits one byte per cycle
// while the output stage can take it. Each input item is accepted in
// S_IDLE, then each lead byte is scanned in S_LEAD, each continuation
// check (including the one that finds a sequence unfinished) runs in
// S_CHECK and each byte is emitted in S_EMIT; S_FLUSH ends the item.
// Output bytes pass through a one-byte staging slot before the output
// register; a byte stays in the slot until another is pushed or the flush.
// A stalled receiver freezes the output register and, once the staging slot
// is full, the sequencer. Reset empties the queue, drops held bytes and
// clears both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_latin1_repair (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_end_of_output
);

    utf8v_pkg::t_state    r_state, n_state;
    utf8v_pkg::t_emit_ctl ctl;
    utf8v_pkg::t_lead     lead;

    logic [7:0] r_q [4];
    logic [7:0] n_q [4];
    logic [2:0] r_nq, n_nq;
    logic [1:0] r_j, n_j;
    logic       r_latin, n_latin;
    logic       r_phase, n_phase;
    logic [2:0] r_left, n_left;
    logic       r_end, n_end;
    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];
    logic [1:0] r_pend_cnt, n_pend_cnt;

    logic       in_acc;
    logic       can;
    logic [7:0] cc;
    logic [7:0] lo, hi;
    logic       in_range;
    logic       incomplete;
    logic       emit_done;

    assign o_stall    = (r_state != utf8v_pkg::S_IDLE);
    assign in_acc     = i_valid && !o_stall;
    assign lead       = utf8v_pkg::lead_info(r_q[0]);
    assign cc         = r_q[r_j];
    assign lo         = (r_j == 2'd1) ? lead.lo : utf8v_pkg::CONT_LO;
    assign hi         = (r_j == 2'd1) ? lead.hi : utf8v_pkg::CONT_HI;
    assign in_range   = (cc >= lo) && (cc <= hi);
    assign incomplete = ({1'b0, r_j} >= r_nq);
    assign emit_done  = r_latin ? r_phase : (r_left == 3'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            utf8v_pkg::S_IDLE: begin
                if (in_acc) n_state = utf8v_pkg::S_LEAD;
            end
            utf8v_pkg::S_LEAD: begin
                if (r_q[0] < utf8v_pkg::ASCII_LIMIT || lead.len == 2'd0) begin
                    n_state = utf8v_pkg::S_EMIT;
                end else begin
                    n_state = utf8v_pkg::S_CHECK;
                end
            end
            utf8v_pkg::S_CHECK: begin
                if (incomplete) begin
                    n_state = r_end ? utf8v_pkg::S_EMIT : utf8v_pkg::S_FLUSH;
                end else if (!in_range || r_j == lead.len) begin
                    n_state = utf8v_pkg::S_EMIT;
                end
            end
            utf8v_pkg::S_EMIT: begin
                if (can && emit_done) begin
                    n_state = (r_nq == 3'd1) ? utf8v_pkg::S_FLUSH : utf8v_pkg::S_LEAD;
                end
            end
            utf8v_pkg::S_FLUSH: begin
                if (can) n_state = utf8v_pkg::S_IDLE;
            end
            default: n_state = utf8v_pkg::S_IDLE;
        endcase
    end

    // datapath and emit control
    always_comb begin
        n_q        = r_q;
        n_nq       = r_nq;
        n_j        = r_j;
        n_latin    = r_latin;
        n_phase    = r_phase;
        n_left     = r_left;
        n_end      = r_end;
        n_pend     = r_pend;
        n_pend_cnt = r_pend_cnt;
        ctl        = '0;
        unique case (r_state)
            utf8v_pkg::S_IDLE: begin
                if (in_acc) begin
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < r_pend_cnt) begin
                            n_q[k] = r_pend[k];
                        end else if (2'(k) == r_pend_cnt) begin
                            n_q[k] = i_in_byte;
                        end
                    end
                    if (r_pend_cnt == 2'd3) n_q[3] = i_in_byte;
                    n_nq       = {1'b0, r_pend_cnt} + 3'd1;
                    n_end      = i_end_of_text;
                    n_pend_cnt = 2'd0;
                end
            end
            utf8v_pkg::S_LEAD: begin
                if (r_q[0] < utf8v_pkg::ASCII_LIMIT) begin
                    n_latin = 1'b0;
                    n_left  = 3'd1;
                end else if (lead.len == 2'd0) begin
                    n_latin = 1'b1;
                    n_phase = 1'b0;
                end else begin
                    n_j = 2'd1;
                end
            end
            utf8v_pkg::S_CHECK: begin
                if (incomplete) begin
                    if (r_end) begin
                        n_latin = 1'b1;
                        n_phase = 1'b0;
                    end else begin
                        // hold the partial sequence for the next item
                        for (int k = 0; k < 3; k++) n_pend[k] = r_q[k];
                        n_pend_cnt = r_nq[1:0];
                    end
                end else if (!in_range) begin
                    n_latin = 1'b1;
                    n_phase = 1'b0;
                end else if (r_j == lead.len) begin
                    n_latin = 1'b0;
                    n_left  = {1'b0, lead.len} + 3'd1;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            utf8v_pkg::S_EMIT: begin
                ctl.push = 1'b1;
                if (r_latin) begin
                    ctl.data = r_phase
                        ? (utf8v_pkg::LATIN_LO_BASE | (r_q[0] & utf8v_pkg::LATIN_MASK))
                        : (utf8v_pkg::LATIN_HI_BASE | {6'd0, r_q[0][7:6]});
                end else begin
                    ctl.data = r_q[0];
                end
                if (can) begin
                    if (r_latin) n_phase = !r_phase;
                    else         n_left  = r_left - 3'd1;
                    if (!r_latin || r_phase) begin
                        for (int k = 0; k < 3; k++) n_q[k] = r_q[k+1];
                        n_nq = r_nq - 3'd1;
                    end
                end
            end
            utf8v_pkg::S_FLUSH: begin
                ctl.flush = 1'b1;
                ctl.eop   = r_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= utf8v_pkg::S_IDLE;
            r_nq       <= 3'd0;
            r_pend_cnt <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_nq       <= n_nq;
            r_pend_cnt <= n_pend_cnt;
        end
        r_q     <= n_q;
        r_j     <= n_j;
        r_latin <= n_latin;
        r_phase <= n_phase;
        r_left  <= n_left;
        r_end   <= n_end;
        r_pend  <= n_pend;
    end

    utf8v_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_can           (can),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_output (o_end_of_output)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utf8v_pkg::S_LEAD || r_state == utf8v_pkg::S_EMIT)
        |-> (r_nq != 3'd0 && r_nq <= 3'd4))
        else $error("byte queue empty or overfull while scanning");

    a_check_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utf8v_pkg::S_CHECK) |-> (lead.len != 2'd0 && r_j != 2'd0 && r_j <= lead.len))
        else $error("continuation index out of range");

    a_nothing_held_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utf8v_pkg::S_FLUSH && r_end) |-> (r_pend_cnt == 2'd0))
        else $error("bytes held past end of string");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utf8v_pkg::S_EMIT && !r_latin) |-> (r_left != 3'd0 && r_left <= r_nq))
        else $error("copy run longer than queue");

endmodule

`default_nettype wire
